[src/pbclk_pkg.sv]
// ----------------------------------------------------------------------------
// pbclk_pkg: shared types and helpers for the playback clock
// Request codes, register indexes, state types and saturating arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package pbclk_pkg;

  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // Time base and speed scaling.
  localparam longint US_PER_SECOND = 1000000;
  localparam longint SPEED_UNIT    = 1000;

  // Error adjust thresholds, all against error_us * 1000.
  localparam logic signed [63:0] ERR_SCALE   = 64'sd1000;
  localparam logic signed [63:0] GATE_LIMIT  = 64'(100 * US_PER_SECOND);
  localparam logic signed [63:0] SNAP_UP     = 64'(20 * US_PER_SECOND);
  localparam logic signed [63:0] SNAP_DOWN   = -64'(27 * US_PER_SECOND);

  localparam logic signed [63:0] RS_MAX = 64'sd131071;
  localparam logic signed [63:0] RS_MIN = -64'sd131072;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_SPEED  = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_ADJUST = 3'd4,
    REQ_TRIM   = 3'd5,
    REQ_VSYNC  = 3'd6,
    REQ_DISC   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    CFG_FREQ   = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_FRAME  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIN
  } md_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ABS_GO,
    ST_ABS_WT,
    ST_TRM_GO,
    ST_TRM_WT,
    ST_T_CALC,
    ST_T_ADD,
    ST_CLK_GO,
    ST_CLK_WT,
    ST_ADJ,
    ST_SPD,
    ST_RATE_GO,
    ST_RATE_WT,
    ST_UNP1,
    ST_UNP2,
    ST_SCL_SUB,
    ST_SCL_GO,
    ST_SCL_WT,
    ST_PAU_GO,
    ST_PAU_WT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] d;
  } md_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [63:0] q;
  } md_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      return a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic [62:0] clamp63(input logic signed [63:0] x);
    if (x[63] == 1'b0 && x[62] == 1'b1) begin
      return {1'b0, {62{1'b1}}};
    end
    if (x[63] == 1'b1 && x[62] == 1'b0) begin
      return {1'b1, 62'd0};
    end
    return x[62:0];
  endfunction

endpackage
`default_nettype wire

[src/playback_clock_with_speed.sv]
// ----------------------------------------------------------------------------
// playback_clock_with_speed: media playback clock with speed, pause and trim
// Turns sampled host ticks into a playing clock in microseconds.
// ----------------------------------------------------------------------------
// Throughput: one request at a time. Each scaled product is one pass through
//   the shared bit-serial multiply/divide unit (64 multiply steps, 128
//   quotient steps and hand-over), and a request uses up to three of them:
//   read and error adjust use three, set speed and resume up to two, pause
//   at most one; trim, vsync, discontinuity and ignored or stored requests
//   use none.
// Reset (rst_n, synchronous, active low) returns all clock state and the
//   registers to their defaults; no clearing pass is needed.
`default_nettype none
module playback_clock_with_speed (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata, low bit first: sys_time[61:0], speed[78:62], error_us[119:79],
  // speed_trim_q16[137:120], vsync_on[138], disc_clock_us[201:139], zero pad
  input  wire logic [207:0] in_tdata,
  // tuser: req_type[2:0]
  input  wire logic [2:0]   in_tuser,
  // Result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata, low bit first: clock_us[62:0], absolute_us[125:63],
  // applied_adjust_us[166:126], zero pad
  output logic [167:0]      out_tdata,
  // Configuration port
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [61:0]  cfg_wdata
);
  import pbclk_pkg::*;

  // Configuration registers
  logic [31:0] freq_r;
  logic [61:0] offset_r;
  logic [19:0] frame_r;

  // Clock state. pause_r of zero means the clock is running.
  logic signed [63:0] start_r, start_nxt;
  logic signed [63:0] pause_r, pause_nxt;
  logic signed [63:0] active_r, active_nxt;
  logic signed [63:0] last_r, last_nxt;
  logic signed [63:0] accum_r, accum_nxt;
  logic signed [17:0] trimv_r, trimv_nxt;
  logic               vsync_r, vsync_nxt;
  logic signed [63:0] doff_r, doff_nxt;
  logic               needrst_r, needrst_nxt;
  logic               paused_r, paused_nxt;
  logic signed [17:0] resume_r, resume_nxt;

  // Captured request and working values
  req_t               req_r, req_nxt;
  logic signed [63:0] sys_r, sys_nxt;
  logic signed [17:0] spd_r, spd_nxt;
  logic signed [40:0] err_r, err_nxt;
  logic signed [63:0] absu_r, absu_nxt;
  logic signed [63:0] clk_r, clkv_nxt;
  logic signed [40:0] adj_r, adj_nxt;
  logic signed [63:0] rate_r, rate_nxt;
  logic signed [63:0] tmp_r, tmp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [167:0]       out_data_r, out_data_nxt;

  state_t state_r, state_nxt;

  md_cmd_t md_cmd;
  md_rsp_t md_rsp;

  logic               in_fire;
  logic               out_load;
  logic signed [63:0] freq_eff;
  logic signed [63:0] errk;
  logic               gated;
  logic signed [40:0] adj_val;
  logic signed [63:0] rs_q;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // A tick frequency of zero is treated as one.
  assign freq_eff = {32'd0, (freq_r == 32'd0) ? 32'd1 : freq_r};

  // Error adjust decision: the error is compared after scaling by a thousand.
  assign errk  = 64'(err_r) * ERR_SCALE;
  assign gated = (trimv_r != 18'sd0) && (errk < GATE_LIMIT);
  always_comb begin
    if (vsync_r) begin
      if (errk > SNAP_UP) begin
        adj_val = 41'(signed'({1'b0, frame_r}));
      end else if (errk < SNAP_DOWN) begin
        adj_val = -41'(signed'({1'b0, frame_r}));
      end else begin
        adj_val = 41'sd0;
      end
    end else begin
      adj_val = err_r;
    end
  end

  // Resume speed taken at pause time is clamped to the 18-bit store.
  always_comb begin
    if (md_rsp.q > RS_MAX) begin
      rs_q = RS_MAX;
    end else if (md_rsp.q < RS_MIN) begin
      rs_q = RS_MIN;
    end else begin
      rs_q = md_rsp.q;
    end
  end

  pbclk_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (md_cmd),
    .rsp   (md_rsp)
  );

  // Operand selection for the shared multiply/divide unit.
  always_comb begin
    md_cmd.start = 1'b0;
    md_cmd.a     = tmp_r;
    md_cmd.b     = 64'(US_PER_SECOND);
    md_cmd.d     = active_r;
    unique case (state_r)
      ST_ABS_GO: begin
        md_cmd.start = 1'b1;
        md_cmd.a     = sys_r - $signed({2'b00, offset_r});
        md_cmd.d     = freq_eff;
      end
      ST_TRM_GO: begin
        md_cmd.start = 1'b1;
        md_cmd.a     = 64'(trimv_r);
        md_cmd.b     = sat_sub(sys_r, last_r);
        md_cmd.d     = 64'sd1;
      end
      ST_CLK_GO: begin
        md_cmd.start = 1'b1;
      end
      ST_RATE_GO: begin
        md_cmd.start = 1'b1;
        md_cmd.a     = freq_eff;
        md_cmd.b     = 64'(SPEED_UNIT);
        md_cmd.d     = 64'(spd_r);
      end
      ST_SCL_GO: begin
        md_cmd.start = 1'b1;
        md_cmd.b     = rate_r;
      end
      ST_PAU_GO: begin
        md_cmd.start = 1'b1;
        md_cmd.a     = freq_eff;
        md_cmd.b     = 64'(SPEED_UNIT);
      end
      default: ;
    endcase
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req_t'(in_tuser))
            REQ_READ, REQ_ADJUST: state_nxt = ST_ABS_GO;
            REQ_SPEED:  state_nxt = paused_r ? ST_DONE : ST_SPD;
            REQ_RESUME: state_nxt = paused_r ? ST_SPD : ST_DONE;
            REQ_PAUSE:  state_nxt = (paused_r || pause_r != 64'sd0) ? ST_DONE : ST_PAU_GO;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ABS_GO:  state_nxt = ST_ABS_WT;
      ST_ABS_WT:  if (md_rsp.done) state_nxt = ST_TRM_GO;
      ST_TRM_GO:  state_nxt = ST_TRM_WT;
      ST_TRM_WT:  if (md_rsp.done) state_nxt = ST_T_CALC;
      ST_T_CALC:  state_nxt = ST_T_ADD;
      ST_T_ADD:   state_nxt = ST_CLK_GO;
      ST_CLK_GO:  state_nxt = ST_CLK_WT;
      ST_CLK_WT:  if (md_rsp.done) state_nxt = (req_r == REQ_ADJUST) ? ST_ADJ : ST_DONE;
      ST_ADJ:     state_nxt = ST_DONE;
      ST_SPD:     state_nxt = (spd_r == 18'sd0) ? ST_DONE : ST_RATE_GO;
      ST_RATE_GO: state_nxt = ST_RATE_WT;
      ST_RATE_WT: if (md_rsp.done) state_nxt = ST_UNP1;
      ST_UNP1:    state_nxt = (pause_r != 64'sd0) ? ST_UNP2 : ST_SCL_SUB;
      ST_UNP2:    state_nxt = ST_SCL_SUB;
      ST_SCL_SUB: state_nxt = ST_SCL_GO;
      ST_SCL_GO:  state_nxt = ST_SCL_WT;
      ST_SCL_WT:  if (md_rsp.done) state_nxt = ST_DONE;
      ST_PAU_GO:  state_nxt = ST_PAU_WT;
      ST_PAU_WT:  if (md_rsp.done) state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: datapath updates
  always_comb begin
    start_nxt   = start_r;
    pause_nxt   = pause_r;
    active_nxt  = active_r;
    last_nxt    = last_r;
    accum_nxt   = accum_r;
    trimv_nxt   = trimv_r;
    vsync_nxt   = vsync_r;
    doff_nxt    = doff_r;
    needrst_nxt = needrst_r;
    paused_nxt  = paused_r;
    resume_nxt  = resume_r;
    req_nxt     = req_r;
    sys_nxt     = sys_r;
    spd_nxt     = spd_r;
    err_nxt     = err_r;
    absu_nxt    = absu_r;
    clkv_nxt    = clk_r;
    adj_nxt     = adj_r;
    rate_nxt    = rate_r;
    tmp_nxt     = tmp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt    = req_t'(in_tuser);
          sys_nxt    = {2'b00, in_tdata[61:0]};
          err_nxt    = in_tdata[119:79];
          absu_nxt   = 64'sd0;
          clkv_nxt   = 64'sd0;
          adj_nxt    = 41'sd0;
          unique case (req_t'(in_tuser))
            REQ_SPEED: begin
              if (paused_r) begin
                resume_nxt = 18'(signed'(in_tdata[78:62]));
              end else begin
                spd_nxt = 18'(signed'(in_tdata[78:62]));
              end
            end
            REQ_RESUME: begin
              if (paused_r) begin
                paused_nxt = 1'b0;
                spd_nxt    = resume_r;
              end
            end
            REQ_PAUSE: begin
              // Already frozen by speed zero: resume speed is zero.
              if (!paused_r && pause_r != 64'sd0) begin
                resume_nxt = 18'sd0;
                paused_nxt = 1'b1;
              end
            end
            REQ_TRIM:  trimv_nxt = in_tdata[137:120];
            REQ_VSYNC: vsync_nxt = in_tdata[138];
            REQ_DISC: begin
              start_nxt   = {2'b00, in_tdata[61:0]};
              if (pause_r != 64'sd0) pause_nxt = {2'b00, in_tdata[61:0]};
              doff_nxt    = 64'(signed'(in_tdata[201:139]));
              needrst_nxt = 1'b0;
              accum_nxt   = 64'sd0;
              trimv_nxt   = 18'sd0;
            end
            default: ;
          endcase
        end
      end
      ST_ABS_WT: begin
        if (md_rsp.done) absu_nxt = md_rsp.q;
      end
      ST_TRM_WT: begin
        if (md_rsp.done) begin
          last_nxt = sys_r;
          if (needrst_r) begin
            // First sample after reset restarts the clock from this tick.
            start_nxt   = sys_r;
            active_nxt  = freq_eff;
            if (pause_r != 64'sd0) pause_nxt = sys_r;
            doff_nxt    = 64'sd0;
            accum_nxt   = 64'sd0;
            trimv_nxt   = 18'sd0;
            vsync_nxt   = 1'b0;
            needrst_nxt = 1'b0;
          end else begin
            accum_nxt = sat_add(accum_r, md_rsp.q);
          end
        end
      end
      ST_T_CALC: begin
        tmp_nxt = sat_sub((pause_r != 64'sd0) ? pause_r : sys_r, start_r);
      end
      ST_T_ADD: begin
        tmp_nxt = sat_add(tmp_r, accum_r >>> 16);
      end
      ST_CLK_WT: begin
        if (md_rsp.done) clkv_nxt = sat_add(md_rsp.q, doff_r);
      end
      ST_ADJ: begin
        if (!gated) begin
          adj_nxt = adj_val;
          if (adj_val != 41'sd0) begin
            start_nxt   = sys_r;
            if (pause_r != 64'sd0) pause_nxt = sys_r;
            doff_nxt    = sat_add(clk_r, 64'(adj_val));
            needrst_nxt = 1'b0;
            accum_nxt   = 64'sd0;
            trimv_nxt   = 18'sd0;
          end
        end
      end
      ST_SPD: begin
        if (spd_r == 18'sd0 && pause_r == 64'sd0) pause_nxt = sys_r;
      end
      ST_RATE_WT: begin
        if (md_rsp.done) begin
          if (md_rsp.q == 64'sd0) begin
            rate_nxt = spd_r[17] ? -64'sd1 : 64'sd1;
          end else begin
            rate_nxt = md_rsp.q;
          end
        end
      end
      ST_UNP1: begin
        if (pause_r != 64'sd0) tmp_nxt = sat_sub(sys_r, pause_r);
      end
      ST_UNP2: begin
        start_nxt = sat_add(start_r, tmp_r);
        pause_nxt = 64'sd0;
      end
      ST_SCL_SUB: begin
        tmp_nxt = sat_sub(sys_r, start_r);
      end
      ST_SCL_WT: begin
        if (md_rsp.done) begin
          start_nxt  = sat_sub(sys_r, md_rsp.q);
          active_nxt = rate_r;
        end
      end
      ST_PAU_WT: begin
        if (md_rsp.done) begin
          resume_nxt = rs_q[17:0];
          pause_nxt  = sys_r;
          paused_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: holds a finished result until the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, adj_r, clamp63(absu_r), clamp63(clk_r)};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      freq_r      <= 32'd1000000;
      offset_r    <= 62'd0;
      frame_r     <= 20'd16667;
      start_r     <= 64'sd0;
      pause_r     <= 64'sd0;
      active_r    <= 64'sd1000000;
      last_r      <= 64'sd0;
      accum_r     <= 64'sd0;
      trimv_r     <= 18'sd0;
      vsync_r     <= 1'b0;
      doff_r      <= 64'sd0;
      needrst_r   <= 1'b1;
      paused_r    <= 1'b0;
      resume_r    <= 18'sd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_FREQ:   freq_r   <= cfg_wdata[31:0];
          CFG_OFFSET: offset_r <= cfg_wdata;
          CFG_FRAME:  frame_r  <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      start_r   <= start_nxt;
      pause_r   <= pause_nxt;
      active_r  <= active_nxt;
      last_r    <= last_nxt;
      accum_r   <= accum_nxt;
      trimv_r   <= trimv_nxt;
      vsync_r   <= vsync_nxt;
      doff_r    <= doff_nxt;
      needrst_r <= needrst_nxt;
      paused_r  <= paused_nxt;
      resume_r  <= resume_nxt;
    end
    req_r      <= req_nxt;
    sys_r      <= sys_nxt;
    spd_r      <= spd_nxt;
    err_r      <= err_nxt;
    absu_r     <= absu_nxt;
    clk_r      <= clkv_nxt;
    adj_r      <= adj_nxt;
    rate_r     <= rate_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The shared unit is never left running once the sequencer is idle.
  a_md_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !md_rsp.busy)
    else $error("multiply/divide unit busy while idle");

  // A result from the unit arrives only while the sequencer waits for one.
  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == ST_ABS_WT || state_r == ST_TRM_WT ||
                     state_r == ST_CLK_WT || state_r == ST_RATE_WT ||
                     state_r == ST_SCL_WT || state_r == ST_PAU_WT))
    else $error("unexpected multiply/divide result");

  // The first sample always leaves the clock started.
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRM_WT && md_rsp.done) |=> !needrst_r)
    else $error("clock not started after first sample");

  // A result is only loaded when the previous one has been taken.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

[src/pbclk_muldiv.sv]
// ----------------------------------------------------------------------------
// pbclk_muldiv: bit-serial multiply then divide
// Computes a*b/d truncated toward zero, saturated to +-(2^63-1); d of zero
// counts as one. One multiplier bit, then one quotient bit, per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pbclk_muldiv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbclk_pkg::md_cmd_t cmd,
  output pbclk_pkg::md_rsp_t     rsp
);
  import pbclk_pkg::*;

  md_state_t   ph_r, ph_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] ua_r, ua_nxt;
  logic [63:0] ud_r, ud_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic signed [63:0] q_r, q_nxt;
  logic        done_r, done_nxt;

  logic [64:0] sum;
  logic [64:0] rsh;
  logic        ge;
  logic [63:0] mag;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ua_r} : 65'd0);
  assign rsh = {rem_r, hi_r[63]};
  assign ge  = rsh >= {1'b0, ud_r};
  assign mag = ((|hi_r) || lo_r[63]) ? 64'(S64_MAX) : lo_r;

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      MD_IDLE: if (cmd.start) ph_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == 7'd63) ph_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == 7'd127) ph_nxt = MD_FIN;
      MD_FIN:  ph_nxt = MD_IDLE;
      default: ph_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    ua_nxt   = ua_r;
    ud_nxt   = ud_r;
    neg_nxt  = neg_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    unique case (ph_r)
      MD_IDLE: begin
        if (cmd.start) begin
          ua_nxt  = cmd.a[63] ? 64'd0 - cmd.a : cmd.a;
          lo_nxt  = cmd.b[63] ? 64'd0 - cmd.b : cmd.b;
          ud_nxt  = (cmd.d == 64'sd0) ? 64'd1 : (cmd.d[63] ? 64'd0 - cmd.d : cmd.d);
          neg_nxt = cmd.a[63] ^ cmd.b[63] ^ cmd.d[63];
          hi_nxt  = 64'd0;
          cnt_nxt = 7'd0;
        end
      end
      MD_MUL: begin
        hi_nxt  = sum[64:1];
        lo_nxt  = {sum[0], lo_r[63:1]};
        cnt_nxt = (cnt_r == 7'd63) ? 7'd0 : cnt_r + 7'd1;
        rem_nxt = 64'd0;
      end
      MD_DIV: begin
        rem_nxt = ge ? 64'(rsh - {1'b0, ud_r}) : rsh[63:0];
        hi_nxt  = {hi_r[62:0], lo_r[63]};
        lo_nxt  = {lo_r[62:0], ge};
        cnt_nxt = cnt_r + 7'd1;
      end
      MD_FIN: begin
        q_nxt    = neg_r ? -$signed(mag) : $signed(mag);
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    ua_r  <= ua_nxt;
    ud_r  <= ud_nxt;
    neg_r <= neg_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy = (ph_r != MD_IDLE);
  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule
`default_nettype wire
